[hdl/trd_pkg.sv]
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types, constants and register codes of the tablet report decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int unsigned WindowBytes    = 24;
  localparam int unsigned SkipAtStart    = 5;
  localparam int unsigned MaxReportBytes = 1024;
  localparam int unsigned PosW           = $clog2(MaxReportBytes + 1);
  localparam int unsigned WinIdxW        = $clog2(WindowBytes);
  localparam int unsigned SkipW          = 3;

  localparam int unsigned AddrW = 5;

  // Register byte addresses
  typedef enum logic [AddrW-1:0] {
    RegType    = 5'd0,
    RegOffset  = 5'd4,
    RegLength  = 5'd8,
    RegId      = 5'd12,
    RegMasks   = 5'd16,
    RegClick   = 5'd20,
    RegKeepTip = 5'd24,
    RegMap     = 5'd28
  } reg_addr_e;

  // Result status codes
  localparam logic [1:0] StatValid  = 2'd0;
  localparam logic [1:0] StatBadPkt = 2'd1;
  localparam logic [1:0] StatBadPos = 2'd2;

  typedef struct packed {
    logic [5:0]  tablet_type;
    logic [5:0]  report_offset;
    logic [10:0] report_length;
    logic [7:0]  report_id_match;
    logic [15:0] button_masks;
    logic [15:0] click_pressure;
    logic [15:0] keep_tip_down;
    logic [15:0] button_map;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  buttons;
    logic [23:0] x;
    logic [23:0] y;
    logic [15:0] z;
    logic [15:0] pressure;
  } result_t;

  typedef logic [WindowBytes-1:0][7:0] window_t;

endpackage

[hdl/trd_stream_if.sv]
// ----------------------------------------------------------------------------
// trd_byte_if / trd_result_if
// Valid/ready channels for report bytes and decoded results.
// ----------------------------------------------------------------------------
interface trd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       end_of_report;
  modport source (output valid, report_byte, end_of_report, input ready);
  modport sink   (input valid, report_byte, end_of_report, output ready);
endinterface

interface trd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_status;
  logic [7:0]  mapped_buttons;
  logic [23:0] pen_x;
  logic [23:0] pen_y;
  logic [15:0] pen_z;
  logic [15:0] pen_pressure;
  modport source (output valid, packet_status, mapped_buttons, pen_x, pen_y, pen_z,
                  pen_pressure, input ready);
  modport sink   (input valid, packet_status, mapped_buttons, pen_x, pen_y, pen_z,
                  pen_pressure, output ready);
endinterface

[hdl/trd_regs.sv]
// ----------------------------------------------------------------------------
// trd_regs
// APB register file holding the decoder configuration.
// ----------------------------------------------------------------------------
module trd_regs
  import trd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tablet_type     <= 6'd34;
      cfg_q.report_offset   <= '0;
      cfg_q.report_length   <= 11'd8;
      cfg_q.report_id_match <= '0;
      cfg_q.button_masks    <= '0;
      cfg_q.click_pressure  <= '0;
      cfg_q.keep_tip_down   <= '0;
      cfg_q.button_map      <= 16'h0321;
    end else if (wr_en) begin
      unique case (paddr)
        RegType:    cfg_q.tablet_type     <= pwdata[5:0];
        RegOffset:  cfg_q.report_offset   <= pwdata[5:0];
        RegLength:  cfg_q.report_length   <= pwdata[10:0];
        RegId:      cfg_q.report_id_match <= pwdata[7:0];
        RegMasks:   cfg_q.button_masks    <= pwdata[15:0];
        RegClick:   cfg_q.click_pressure  <= pwdata[15:0];
        RegKeepTip: cfg_q.keep_tip_down   <= pwdata[15:0];
        RegMap:     cfg_q.button_map      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr)
      RegType:    prdata = {26'd0, cfg_q.tablet_type};
      RegOffset:  prdata = {26'd0, cfg_q.report_offset};
      RegLength:  prdata = {21'd0, cfg_q.report_length};
      RegId:      prdata = {24'd0, cfg_q.report_id_match};
      RegMasks:   prdata = {16'd0, cfg_q.button_masks};
      RegClick:   prdata = {16'd0, cfg_q.click_pressure};
      RegKeepTip: prdata = {16'd0, cfg_q.keep_tip_down};
      RegMap:     prdata = {16'd0, cfg_q.button_map};
      default:    prdata = '0;
    endcase
  end

endmodule

[hdl/trd_capture.sv]
// ----------------------------------------------------------------------------
// trd_capture
// Byte position counter and capture window; hands the finished window on
// as a registered frame at the end of each report.
// ----------------------------------------------------------------------------
module trd_capture
  import trd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      take_i,
  input  logic [7:0] byte_i,
  input  logic      eor_i,
  input  logic      frame_take_i,
  output logic      frame_vld_o,
  output window_t   frame_o
);

  window_t         win_q, win_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [5:0]      start;
  logic [PosW-1:0] rel;
  logic            frame_vld_q;
  window_t         frame_q;

  // Window start from offset and the layout quirks
  always_comb begin
    start = cfg_i.report_offset;
    if (cfg_i.tablet_type == 6'd35 && start == 6'd0) start = 6'd1;
    if ((cfg_i.tablet_type == 6'd0 || cfg_i.tablet_type == 6'd14) &&
        cfg_i.report_length == 11'd11 && cfg_i.report_offset == 6'd0) start = 6'd1;
    if (cfg_i.tablet_type == 6'd1 && cfg_i.report_length == 11'd193) start = 6'd1;
  end

  assign rel = pos_q - PosW'(start);

  // Window write with the incoming byte folded in
  always_comb begin
    win_d = win_q;
    pos_d = pos_q;
    if (pos_q < PosW'(MaxReportBytes)) begin
      if (pos_q >= PosW'(start) && rel < PosW'(WindowBytes))
        win_d[rel[WinIdxW-1:0]] = byte_i;
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      pos_q       <= '0;
      frame_vld_q <= 1'b0;
    end else begin
      // Frame stays valid until the decoder takes it
      frame_vld_q <= (take_i & eor_i) | (frame_vld_q & ~frame_take_i);
      if (take_i) begin
        if (eor_i) begin
          win_q <= '0;
          pos_q <= '0;
        end else begin
          win_q <= win_d;
          pos_q <= pos_d;
        end
      end
    end
  end

  // Frame register, payload only
  always_ff @(posedge clk_i) begin
    if (take_i && eor_i) frame_q <= win_d;
  end

  assign frame_vld_o = frame_vld_q;
  assign frame_o     = frame_q;

endmodule

[hdl/trd_decode.sv]
// ----------------------------------------------------------------------------
// trd_decode
// Layout decode of a captured window plus the report checks, tip rule,
// tip hold counter, button remap and start-up skip. Purely combinational
// apart from the skip and hold counters, which advance on frame_take_i.
// ----------------------------------------------------------------------------
module trd_decode
  import trd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  window_t win_i,
  input  logic    frame_take_i,
  output result_t res_o
);

  logic [SkipW-1:0] skip_q;
  logic signed [16:0] hold_q, hold_d;

  logic [7:0]  w [WindowBytes];
  logic [1:0]  st;
  logic [7:0]  rid, b;
  logic [23:0] x, y;
  logic [15:0] z, p;
  logic [7:0]  d0, d1, d2, d4, d5, d9;
  logic [7:0]  det, ign;
  logic [3:0]  bt;
  logic [3:0]  m;
  logic [7:0]  outb;
  logic [5:0]  ty;

  always_comb begin
    for (int i = 0; i < WindowBytes; i++) w[i] = win_i[i];
  end

  function automatic logic [15:0] le16(input logic [7:0] lo, input logic [7:0] hi);
    return {hi, lo};
  endfunction

  assign d0 = w[0];
  assign d1 = w[1];
  assign d2 = w[2];
  assign d4 = w[4];
  assign d5 = w[5];
  assign d9 = w[9];
  assign ty = (cfg_i.tablet_type > 6'd35) ? 6'd34 : cfg_i.tablet_type;

  // Layout decode
  always_comb begin
    st = StatValid; rid = d0; b = '0; x = '0; y = '0; z = '0; p = '0;
    case (ty)
      6'd0, 6'd14: begin
        b = (ty == 6'd0) ? (d1 & 8'hFE) : d1;
        x = {7'd0, w[2], w[3], d9[1]};
        y = {7'd0, w[4], w[5], d9[0]};
        p = {5'd0, w[6], w[7][7:6], d1[0]};
        if (ty == 6'd14) z = {10'd0, d9[7:2]};
      end
      6'd1: begin
        b = d1 & 8'hFE; x = {d4, w[3], d2}; y = {w[7], w[6], d5};
        p = le16(w[8], w[9]);
      end
      6'd2: begin
        if (d0 == 8'h10) begin
          b = d1 & 8'hFE; x = {d4, w[3], d2}; y = {w[7], w[6], d5};
          p = le16(w[8], w[9]); z = {8'd0, w[16]};
        end else if (d0 == 8'h1E) begin
          b = (d2 & 8'hFE) | (d1 & 8'h20);
          x = {d5, d4, w[3]}; y = {w[8], w[7], w[6]};
          p = le16(w[9], w[10]); z = {8'd0, w[11]};
        end else st = StatBadPkt;
      end
      6'd3: begin
        if (d0 == 8'h1F && d1 == 8'h01) begin
          b = d2 & 8'hFE; x = {8'd0, le16(w[3], w[4])}; y = {8'd0, le16(w[5], w[6])};
          p = le16(w[7], w[8]); z = {8'd0, w[13]};
        end else if (d0 == 8'h1E) begin
          b = d2 & 8'hFE; x = {d5, d4, w[3]}; y = {w[8], w[7], w[6]};
          p = le16(w[9], w[10]); z = {8'd0, w[19]};
        end else st = StatBadPkt;
      end
      6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd11, 6'd17, 6'd18, 6'd27, 6'd28: begin
        if ((ty == 6'd4 && (d1 == 8'hC0 || d1[6])) ||
            (ty == 6'd5 && (d1 == 8'hE0 || !d1[6])) ||
            (ty == 6'd6 && (d1 == 8'hE0 || d1 == 8'hF0)) ||
            (ty == 6'd7 && (d1 == 8'h00 || d1 == 8'hE0 || d1 == 8'hE3 || d1 == 8'hF1 ||
                            !d1[7])) ||
            ((ty == 6'd8 || ty == 6'd9) && (d1 == 8'hC0 || d1[4])) ||
            (ty == 6'd11 && (d1 == 8'hC0 || d1[5])) ||
            (ty == 6'd17 && (d0 != 8'd1 || !d1[5])) ||
            (ty == 6'd18 && d0 != 8'h10) ||
            (ty == 6'd27 && (d1[7:4] == 4'hF || !d1[5])) ||
            (ty == 6'd28 && (d0 != 8'd1 || d1 == 8'd0)))
          st = StatBadPos;
        if (ty == 6'd5) b = d1 & 8'hBE;
        else if (ty == 6'd7) b = d1 & 8'h7E;
        else if (ty == 6'd17 || ty == 6'd27) b = d1 & 8'h0E;
        else if (ty == 6'd18) b = d1 & 8'h0F;
        else if (ty == 6'd28) b = d1 & 8'h46;
        else b = d1 & 8'hFE;
        x = {8'd0, le16(w[2], w[3])}; y = {8'd0, le16(w[4], w[5])};
        p = le16(w[6], w[7]);
        if (ty == 6'd9 && cfg_i.report_length >= 11'd10) p = p & 16'h1FFF;
        if ((ty == 6'd8 || ty == 6'd9) && cfg_i.report_length >= 11'd12) begin
          x[23:16] = w[10]; y[23:16] = w[11];
        end
      end
      6'd10: begin
        if (d1 == 8'hC0 || d1 == 8'hF0 || d1[7:4] != 4'hA) st = StatBadPos;
        b = d1 & 8'h5E;
        x = {w[10], le16(w[2], w[3])}; y = {w[11], le16(w[4], w[5])};
        p = (le16(w[6], w[7]) & 16'hBFFF) | {2'd0, w[13][0], 13'd0};
      end
      6'd12: begin
        if (d1 == 8'hF1 || (d1[5] && d1[6])) st = StatBadPos;
        b = d1 & 8'hFE;
        x = {7'd0, w[8][0], le16(w[2], w[3])}; y = {7'd0, d9[0], le16(w[4], w[5])};
        p = le16(w[6], w[7]);
      end
      6'd13, 6'd29: begin
        b = d1 & 8'h07;
        x = {8'd0, le16(w[2], w[3])}; y = {8'd0, le16(w[4], w[5])};
        p = d1[0] ? {6'd0, w[7][1:0], w[6]} : 16'd0;
        if ((ty == 6'd29 && d0 != 8'd2) ||
            (!d1[7] && x == '0 && y == '0 && p == '0)) st = StatBadPos;
      end
      6'd15, 6'd24: begin
        if ((ty == 6'd24 && d0 == 8'd3) || d1 != 8'h41 || d2[7:4] != 4'hA) st = StatBadPos;
        rid = d1; b = d2 & 8'h06;
        x = {8'd0, le16(w[3], w[4])}; y = {8'd0, le16(w[5], w[6])}; p = le16(w[7], w[8]);
      end
      6'd16: begin
        if (d1 == 8'd0) st = StatBadPos;
        b = {5'd0, d1[1], d1[5], 1'b0};
        x = {8'd0, le16(w[2], w[3])}; y = {8'd0, le16(w[4], w[5])}; p = le16(w[6], w[7]);
      end
      6'd19, 6'd20: begin
        if (d0 != 8'd2) st = StatBadPos;
        b = {5'd0, d5[4], d5[3], 1'b0};
        x = {8'd0, le16(w[1], w[2])}; y = {8'd0, le16(w[3], w[4])};
        p = (ty == 6'd20 || d5[2]) ? le16(w[6], w[7]) : 16'd0;
      end
      6'd21: begin
        if (d1 != 8'h42) st = StatBadPos;
        rid = d1; b = {6'd0, w[11][1], 1'b0};
        x = {8'd0, le16(w[6], w[7])}; y = {8'd0, le16(w[8], w[9])}; p = le16(w[10], w[11]);
      end
      6'd22, 6'd23, 6'd25: begin
        if (ty == 6'd25) begin
          if (d1 != 8'h41 || d2 == 8'hC0) st = StatBadPos;
        end else if (d1 == 8'h43 || !d2[5]) st = StatBadPos;
        rid = d1; b = d2 & 8'h06;
        if (ty == 6'd23) begin
          x = {8'd0, le16(w[3], w[4])}; y = {8'd0, le16(w[5], w[6])}; p = le16(w[7], w[8]);
        end else begin
          x = {d5, le16(w[3], w[4])}; y = {w[8], le16(w[6], w[7])}; p = le16(w[9], w[10]);
        end
      end
      6'd26: begin
        if (d9[1:0] != 2'b11) st = StatBadPos;
        b = {5'd0, d9[4], d9[3], 1'b0};
        x = {8'd0, le16(w[1], w[2])}; y = {8'd0, le16(w[5], w[6])};
        p = d9[2] ? le16(w[10], w[11]) : 16'd0;
      end
      6'd30: begin
        if (d0 != 8'h10 || d1 != 8'd1) st = StatBadPos;
        b = {6'd0, d2[1], 1'b0};
        x = {8'd0, le16(w[3], w[4])}; y = {8'd0, le16(w[5], w[6])}; p = le16(w[7], w[8]);
      end
      6'd31: begin
        if ((d0 != 8'd2 && d0 != 8'h10) || (d0 == 8'h10 && d1 == 8'h20) || d1 == 8'h80 ||
            (!d1[5] && (d1 & 8'h0A) != 8'h0A)) st = StatBadPos;
        b = d1 & 8'hFE;
        x = {7'd0, w[2], w[3], d9[1]};
        y = {7'd0, w[4], w[5], d9[0]};
        p = {5'd0, w[6], w[7][7:6], d1[0]};
        z = {8'd0, d9};
      end
      6'd32: begin
        if (!d1[6]) st = StatBadPos;
        b = {5'd0, d4[5], d4[4], 1'b0};
        x = {8'd0, d1[1:0], 14'd0} | {9'd0, d2, 7'd0} | {16'd0, w[3]};
        y = {8'd0, d4[1:0], 14'd0} | {9'd0, d5, 7'd0} | {16'd0, w[6]};
        p = {6'd0, w[7] ^ 8'h40, 2'd0} | {14'd0, d4[6], d4[2]};
      end
      6'd33: begin
        b = {4'd0, d1[2], d1[4], d1[1], 1'b0};
        x = {8'd0, le16(w[2], w[3])}; y = {8'd0, le16(w[4], w[5])}; p = le16(w[6], w[7]);
        if (!d1[5] && x == '0 && y == '0 && p == '0) st = StatBadPos;
      end
      default: begin
        b = d1; x = {8'd0, le16(w[2], w[3])}; y = {8'd0, le16(w[4], w[5])};
        p = le16(w[6], w[7]); z = le16(w[8], w[9]);
      end
    endcase
  end

  // Checks, tip rule, hold counter and remap
  always_comb begin
    det   = cfg_i.button_masks[7:0];
    ign   = cfg_i.button_masks[15:8];
    res_o = '0;
    hold_d = hold_q;
    bt = b[3:0];
    outb = '0;
    m = '0;
    if (skip_q != '0) begin
      res_o.status = StatBadPkt;
    end else if (st != StatValid) begin
      res_o.status = st;
    end else if (cfg_i.report_id_match != 8'd0 && rid != cfg_i.report_id_match) begin
      res_o.status = StatBadPkt;
    end else if ((det != 8'd0 && (b & det) != det) || (ign != 8'd0 && (b & ign) == ign)) begin
      res_o.status = StatBadPos;
    end else begin
      if (cfg_i.click_pressure != 16'd0) bt[0] = (p > cfg_i.click_pressure);
      else if (p > 16'd1) bt[0] = 1'b1;
      if (cfg_i.keep_tip_down != 16'd0) begin
        if (bt[0]) hold_d = signed'({1'b0, cfg_i.keep_tip_down});
        if (!hold_d[16]) begin
          bt[0]  = 1'b1;
          hold_d = hold_d - 17'sd1;
        end
      end
      for (int i = 0; i < 4; i++) begin
        m = cfg_i.button_map[4*i +: 4];
        if (m >= 4'd1 && m <= 4'd8 && bt[i]) outb[3'(m - 4'd1)] = 1'b1;
      end
      res_o.status   = StatValid;
      res_o.buttons  = outb;
      res_o.x        = x;
      res_o.y        = y;
      res_o.z        = z;
      res_o.pressure = p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= SkipW'(SkipAtStart);
      hold_q <= '0;
    end else if (frame_take_i) begin
      if (skip_q != '0) skip_q <= skip_q - 1'b1;
      hold_q <= hold_d;
    end
  end

`ifndef SYNTHESIS
  // Skip counter only ever counts down
  a_skip_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= $past(skip_q)) else $error("skip counter rose");
  // Hold counter never goes below minus one
  a_hold_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q >= -17'sd1) else $error("tip hold below floor");
  // A skipped report is always reported invalid
  a_skip_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q != '0 |-> res_o.status == StatBadPkt) else $error("skip status");
`endif

endmodule

[hdl/tablet_report_decoder_top.sv]
// ----------------------------------------------------------------------------
// tablet_report_decoder_top
// Pen-tablet report decoder: byte capture, layout decode, result output.
// ----------------------------------------------------------------------------
// Report bytes are taken one per cycle. On the final byte of a report the
// captured window is registered as a frame, decoded combinationally by the
// selected layout and written to the result register once that is free or
// draining. A byte is accepted every cycle unless a finished result is
// stalled at the output with a new one ready behind it. Configuration must
// be written over APB only while the block is idle; the block does not enforce it.
module tablet_report_decoder_top
  import trd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  trd_byte_if.sink         in_if,
  trd_result_if.source     out_if
);

  cfg_t    cfg;
  window_t frame;
  logic    frame_vld, frame_take, take;
  result_t res, res_q;
  logic    out_vld_q;

  trd_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // Output register free or draining this cycle
  assign frame_take = frame_vld & (~out_vld_q | out_if.ready);
  // Hold input while a frame waits for the output register
  assign in_if.ready = ~(frame_vld & ~frame_take);
  assign take = in_if.valid & in_if.ready;

  trd_capture u_capture (
    .clk_i, .rst_ni, .cfg_i(cfg), .take_i(take), .byte_i(in_if.report_byte),
    .eor_i(in_if.end_of_report), .frame_take_i(frame_take), .frame_vld_o(frame_vld),
    .frame_o(frame)
  );

  trd_decode u_decode (
    .clk_i, .rst_ni, .cfg_i(cfg), .win_i(frame), .frame_take_i(frame_take), .res_o(res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (frame_take) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take) res_q <= res;
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.packet_status  = res_q.status;
  assign out_if.mapped_buttons = res_q.buttons;
  assign out_if.pen_x          = res_q.x;
  assign out_if.pen_y          = res_q.y;
  assign out_if.pen_z          = res_q.z;
  assign out_if.pen_pressure   = res_q.pressure;

endmodule
